FILE: sv/csc_pkg.sv
// types, constants and helper functions shared by the sprite compositor
package csc_pkg;

   localparam int MAX_SHAPES = 16;
   localparam int MAP_ROWS   = 30;
   localparam int MAP_COLS   = 60;
   localparam int CNT_W      = $clog2(MAX_SHAPES + 1);
   localparam int CMP_W      = (CNT_W > 5) ? CNT_W : 5;
   localparam int CROSS_MID  = 3;

   localparam logic [6:0] CH_DASH  = 7'h2D;
   localparam logic [6:0] CH_BAR   = 7'h7C;
   localparam logic [6:0] CH_SPACE = 7'h20;

   typedef enum logic [2:0] {
      MODE_APPEND = 3'd0,
      MODE_INSERT = 3'd1,
      MODE_REMOVE = 3'd2,
      MODE_CLEAR  = 3'd3,
      MODE_QUERY  = 3'd4
   } mode_type;

   typedef enum logic [1:0] {
      ST_OK     = 2'd0,
      ST_BADIDX = 2'd1,
      ST_EMPTY  = 2'd2,
      ST_FULL   = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      KIND_LINE   = 2'd0,
      KIND_CROSS  = 2'd1,
      KIND_SQUARE = 2'd2,
      KIND_BAR    = 2'd3
   } kind_type;

   typedef struct packed {
      kind_type          kind;
      logic signed [7:0] x;
      logic signed [7:0] y;
   } shape_type;

   typedef struct packed {
      logic load;
      logic take_prev;
      logic take_next;
      logic active;
   } cell_ctl_type;

   typedef struct packed {
      logic       valid;
      logic       open;
      logic [4:0] row;
      logic [5:0] col;
      status_type status;
      logic [6:0] cell_char;
      logic [4:0] shape_count;
   } stage_word_type;

   function automatic logic [3:0] kind_width(kind_type kind);
      logic [3:0] w;
      unique case (kind)
         KIND_LINE:   w = 4'd1;
         KIND_CROSS:  w = 4'd7;
         KIND_SQUARE: w = 4'd2;
         KIND_BAR:    w = 4'd8;
         default:     w = 4'd0;
      endcase
      return w;
   endfunction

   function automatic logic [3:0] kind_height(kind_type kind);
      logic [3:0] h;
      unique case (kind)
         KIND_LINE:   h = 4'd3;
         KIND_CROSS:  h = 4'd7;
         KIND_SQUARE: h = 4'd2;
         KIND_BAR:    h = 4'd2;
         default:     h = 4'd0;
      endcase
      return h;
   endfunction

   function automatic logic [6:0] kind_char(kind_type kind);
      logic [6:0] c;
      unique case (kind)
         KIND_LINE:   c = 7'h41;
         KIND_CROSS:  c = 7'h43;
         KIND_SQUARE: c = 7'h44;
         KIND_BAR:    c = 7'h47;
         default:     c = 7'h00;
      endcase
      return c;
   endfunction

endpackage

FILE: sv/csc_if.sv
// valid/ready channel interfaces for requests and responses
interface csc_req_if;
   logic       valid;
   logic       ready;
   logic [2:0] mode;
   logic [4:0] slot_index;
   logic [1:0] shape_kind;
   logic signed [7:0] origin_x;
   logic signed [7:0] origin_y;
   logic [4:0] cell_row;
   logic [5:0] cell_col;

   modport source (output valid, mode, slot_index, shape_kind, origin_x, origin_y,
                   cell_row, cell_col, input ready);
   modport sink (input valid, mode, slot_index, shape_kind, origin_x, origin_y,
                 cell_row, cell_col, output ready);
endinterface

interface csc_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] status;
   logic [6:0] cell_char;
   logic [4:0] shape_count;

   modport source (output valid, status, cell_char, shape_count, input ready);
   modport sink (input valid, status, cell_char, shape_count, output ready);
endinterface

FILE: sv/character_sprite_compositor.sv
// top level: request decode, entry stage and the chain of shape cells
//
//  channel   dir   handshake     word
//  req_ch    in    valid/ready   mode, slot_index, shape_kind, origin_x/y, cell_row/col
//  rsp_ch    out   valid/ready   status, cell_char, shape_count
//
// every word goes through the entry stage and one stage per cell; queries enter one per cycle
// unless the response stalls; a table change waits until no interior query is in the chain
// table changes take effect at the accept edge; the count resets to zero, table entries do not
// a stalled response freezes the whole chain and holds off new requests

module character_sprite_compositor
   import csc_pkg::*;
(
   input logic       clock,
   input logic       reset,
   csc_req_if.sink   req_ch,
   csc_rsp_if.source rsp_ch
);

   logic [CNT_W-1:0] count_ff, count_in;
   stage_word_type   entry_ff, entry_in;
   stage_word_type   chain_word [MAX_SHAPES+1];
   shape_type        cell_shape [MAX_SHAPES];
   shape_type        prev_sh    [MAX_SHAPES];
   shape_type        next_sh    [MAX_SHAPES];
   cell_ctl_type     cell_ctl   [MAX_SHAPES];
   shape_type        new_shape;
   logic advance, chain_busy, accept, is_query;
   logic do_ins, do_rm;
   logic [CMP_W-1:0] idx_ext, cnt_ext, ins_pos, rm_pos;

   assign advance  = !chain_word[MAX_SHAPES].valid || rsp_ch.ready;
   assign is_query = (mode_type'(req_ch.mode) == MODE_QUERY);
   assign req_ch.ready = advance && (is_query || !chain_busy);
   assign accept   = req_ch.valid && req_ch.ready;
   assign idx_ext  = CMP_W'(req_ch.slot_index);
   assign cnt_ext  = CMP_W'(count_ff);
   assign new_shape = '{kind: kind_type'(req_ch.shape_kind), x: req_ch.origin_x,
                        y: req_ch.origin_y};

   always_comb begin
      chain_busy = 1'b0;
      for (int i = 0; i < MAX_SHAPES; i++) begin
         chain_busy = chain_busy || (chain_word[i].valid && chain_word[i].open);
      end
   end

   always_comb begin
      entry_in = '0;
      entry_in.valid = 1'b1;
      entry_in.row = req_ch.cell_row;
      entry_in.col = req_ch.cell_col;
      entry_in.status = ST_OK;
      count_in = count_ff;
      do_ins = 1'b0;
      do_rm = 1'b0;
      ins_pos = cnt_ext;
      rm_pos = idx_ext;
      unique case (mode_type'(req_ch.mode))
         MODE_APPEND: begin
            if (cnt_ext >= CMP_W'(MAX_SHAPES)) begin
               entry_in.status = ST_FULL;
            end else begin
               do_ins = 1'b1;
            end
         end
         MODE_INSERT: begin
            ins_pos = idx_ext;
            priority if (idx_ext > cnt_ext) begin
               entry_in.status = ST_BADIDX;
            end else if (cnt_ext >= CMP_W'(MAX_SHAPES)) begin
               entry_in.status = ST_FULL;
            end else begin
               do_ins = 1'b1;
            end
         end
         MODE_REMOVE: begin
            priority if (count_ff == '0) begin
               entry_in.status = ST_EMPTY;
            end else if (idx_ext >= cnt_ext) begin
               entry_in.status = ST_BADIDX;
            end else begin
               do_rm = 1'b1;
            end
         end
         MODE_CLEAR: begin
            count_in = '0;
         end
         MODE_QUERY: begin
            priority if (req_ch.cell_row >= 5'(MAP_ROWS) || req_ch.cell_col >= 6'(MAP_COLS)) begin
               entry_in.status = ST_BADIDX;
            end else if (req_ch.cell_row == '0 || req_ch.cell_row == 5'(MAP_ROWS - 1)) begin
               entry_in.cell_char = CH_DASH;
            end else if (req_ch.cell_col == '0 || req_ch.cell_col == 6'(MAP_COLS - 1)) begin
               entry_in.cell_char = CH_BAR;
            end else begin
               entry_in.cell_char = CH_SPACE;
               entry_in.open = 1'b1;
            end
         end
         default: begin
         end
      endcase
      if (do_ins) begin
         count_in = count_ff + CNT_W'(1);
      end
      if (do_rm) begin
         count_in = count_ff - CNT_W'(1);
      end
      entry_in.shape_count = 5'(count_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         entry_ff.valid <= 1'b0;
      end else if (advance) begin
         if (accept) begin
            count_ff <= count_in;
            entry_ff <= entry_in;
         end else begin
            entry_ff.valid <= 1'b0;
         end
      end
   end

   assign chain_word[0] = entry_ff;

   for (genvar i = 0; i < MAX_SHAPES; i++) begin : g_cell
      if (i == 0) begin : g_first
         assign prev_sh[i] = new_shape;
      end else begin : g_mid
         assign prev_sh[i] = cell_shape[i-1];
      end
      if (i == MAX_SHAPES - 1) begin : g_last
         assign next_sh[i] = cell_shape[i];
      end else begin : g_inner
         assign next_sh[i] = cell_shape[i+1];
      end

      assign cell_ctl[i] = '{
         load:      accept && do_ins && (ins_pos == CMP_W'(i)),
         take_prev: accept && do_ins && (CMP_W'(i) > ins_pos),
         take_next: accept && do_rm && (CMP_W'(i) >= rm_pos),
         active:    CNT_W'(i) < count_ff
      };

      csc_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .advance    (advance),
         .ctl        (cell_ctl[i]),
         .new_shape  (new_shape),
         .prev_shape (prev_sh[i]),
         .next_shape (next_sh[i]),
         .shape_out  (cell_shape[i]),
         .word_in    (chain_word[i]),
         .word_out   (chain_word[i+1])
      );
   end

   assign rsp_ch.valid       = chain_word[MAX_SHAPES].valid;
   assign rsp_ch.status      = chain_word[MAX_SHAPES].status;
   assign rsp_ch.cell_char   = chain_word[MAX_SHAPES].cell_char;
   assign rsp_ch.shape_count = chain_word[MAX_SHAPES].shape_count;

   a_change_when_clear: assert property (@(posedge clock) disable iff (reset)
      accept && !is_query |-> !chain_busy)
      else $error("table change accepted with a query in the chain");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      CMP_W'(count_ff) <= CMP_W'(MAX_SHAPES))
      else $error("shape count above table depth");

   a_clear_empties: assert property (@(posedge clock) disable iff (reset)
      accept && mode_type'(req_ch.mode) == MODE_CLEAR |=> count_ff == '0)
      else $error("clear left shapes in the table");

   a_stall_freezes: assert property (@(posedge clock) disable iff (reset)
      !advance |=> $stable(count_ff) && $stable(entry_ff))
      else $error("entry stage moved during a response stall");

endmodule

FILE: sv/csc_cell.sv
// one table cell: holds a shape, shifts with its neighbors, paints passing query words
module csc_cell
   import csc_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           advance,
   input  cell_ctl_type   ctl,
   input  shape_type      new_shape,
   input  shape_type      prev_shape,
   input  shape_type      next_shape,
   output shape_type      shape_out,
   input  stage_word_type word_in,
   output stage_word_type word_out
);

   shape_type      shape_ff, shape_in;
   stage_word_type word_ff, word_in_d;
   logic signed [8:0] dr, dc;
   logic origin_ok, row_ok, col_ok, cross_ok, covered;

   always_comb begin
      origin_ok = (shape_ff.x > 8'sd0) && (shape_ff.x < $signed(8'(MAP_COLS - 1)))
               && (shape_ff.y > 8'sd0) && (shape_ff.y < $signed(8'(MAP_ROWS - 1)));
      dr = $signed({4'b0, word_in.row}) - $signed({shape_ff.y[7], shape_ff.y});
      dc = $signed({3'b0, word_in.col}) - $signed({shape_ff.x[7], shape_ff.x});
      row_ok = !dr[8] && (dr[7:0] < {4'b0, kind_height(shape_ff.kind)});
      col_ok = !dc[8] && (dc[7:0] < {4'b0, kind_width(shape_ff.kind)});
      cross_ok = (shape_ff.kind != KIND_CROSS) || (dr == 9'(CROSS_MID))
              || (dc == 9'(CROSS_MID));
      covered = ctl.active && origin_ok && row_ok && col_ok && cross_ok;
   end

   always_comb begin
      word_in_d = word_in;
      if (word_in.valid && word_in.open && covered) begin
         word_in_d.cell_char = kind_char(shape_ff.kind);
      end
   end

   always_comb begin
      shape_in = shape_ff;
      priority if (ctl.load) begin
         shape_in = new_shape;
      end else if (ctl.take_prev) begin
         shape_in = prev_shape;
      end else if (ctl.take_next) begin
         shape_in = next_shape;
      end
   end

   always_ff @(posedge clock) begin
      shape_ff <= shape_in;
      if (reset) begin
         word_ff.valid <= 1'b0;
      end else if (advance) begin
         word_ff <= word_in_d;
      end
   end

   assign shape_out = shape_ff;
   assign word_out  = word_ff;

   a_one_shift: assert property (@(posedge clock) disable iff (reset)
      $onehot0({ctl.load, ctl.take_prev, ctl.take_next}))
      else $error("cell asked for more than one table move");

   a_closed_passes: assert property (@(posedge clock) disable iff (reset)
      advance && word_in.valid && !word_in.open |=> word_out.cell_char == $past(word_in.cell_char))
      else $error("cell painted a word that is not an interior query");

   a_no_move_in_query: assert property (@(posedge clock) disable iff (reset)
      word_in.valid && word_in.open |-> !(ctl.load || ctl.take_prev || ctl.take_next))
      else $error("table moved under a query in flight");

endmodule
